@@ design/obm_pkg.sv @@
package obm_pkg;

    // Fixed page geometry and address room for the largest store
    localparam int PAGE_BYTES  = 8;
    localparam int ADDR_W      = 7;
    localparam int QUEUE_DEPTH = 4;

    // Function command codes
    localparam logic [7:0] CMD_READ_SP  = 8'hBE;
    localparam logic [7:0] CMD_WRITE_SP = 8'h4E;
    localparam logic [7:0] CMD_COPY_SP  = 8'h48;
    localparam logic [7:0] CMD_RECALL   = 8'hB8;
    localparam logic [7:0] CMD_CONV_T   = 8'h44;
    localparam logic [7:0] CMD_CONV_V   = 8'hB4;

    // Configuration register indexes
    localparam logic [1:0] REG_TEMP = 2'd0;
    localparam logic [1:0] REG_CURR = 2'd1;
    localparam logic [1:0] REG_VAD  = 2'd2;
    localparam logic [1:0] REG_VDD  = 2'd3;

    // Temperature limits in 1/256 degC
    localparam logic signed [15:0] T_MAX = 16'sd32000;
    localparam logic signed [15:0] T_MIN = -16'sd14080;

    // Reset value of page 0 byte 0
    localparam logic [7:0] CTL0_RESET = 8'h03;

    typedef enum logic [1:0] {
        JOB_READ,
        JOB_WRITE,
        JOB_CONV_V,
        JOB_ERROR
    } t_job_op;

    typedef struct packed {
        t_job_op             op;
        logic [ADDR_W-1:0]   addr;
        logic [7:0]          data;
    } t_job;

    typedef struct packed {
        logic signed [15:0] temperature_q8;
        logic signed [9:0]  current_reading;
        logic [9:0]         vad_voltage;
        logic [9:0]         vdd_voltage;
    } t_cfg;

    // One byte of the reflected CRC8 (x^8+x^5+x^4+1)
    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ 8'h8C) : (c >> 1);
        end
        return c;
    endfunction

endpackage

@@ design/obm_if.sv @@
interface obm_in_if;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic [7:0] rx_byte;

    modport source (output valid, output req_type, output rx_byte, input ready);
    modport sink   (input valid, input req_type, input rx_byte, output ready);
endinterface

interface obm_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] tx_byte;
    logic       is_error;
    logic       last_of_run;

    modport source (output valid, output tx_byte, output is_error, output last_of_run,
                    input ready);
    modport sink   (input valid, input tx_byte, input is_error, input last_of_run,
                    output ready);
endinterface

interface obm_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ design/obm_front.sv @@
module obm_front #(
    parameter int PAGES = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    obm_in_if.sink       i_in,
    input  logic         i_q_full,
    output logic         o_push,
    output obm_pkg::t_job o_job
);
    import obm_pkg::*;

    typedef enum logic [1:0] {PH_CMD, PH_PAGE, PH_WRITE, PH_IDLE} t_phase;
    typedef enum logic [2:0] {PC_NONE, PC_READ, PC_WRITE, PC_COPY, PC_RECALL} t_pend;

    t_phase            r_phase, n_phase;
    t_pend             r_pend, n_pend;
    logic [ADDR_W-1:0] r_base, n_base;
    logic [2:0]        r_wcnt, n_wcnt;

    logic              w_accept;
    logic [ADDR_W-1:0] w_page_base;
    logic [ADDR_W-1:0] w_wr_addr;

    assign i_in.ready  = !i_q_full;
    assign w_accept    = i_in.valid && !i_q_full;
    assign w_page_base = ADDR_W'({i_in.rx_byte, 3'b000});
    assign w_wr_addr   = r_base | ADDR_W'(r_wcnt);

    // Classify the incoming word and hand work to the back end
    always_comb begin
        n_phase = r_phase;
        n_pend  = r_pend;
        n_base  = r_base;
        n_wcnt  = r_wcnt;
        o_push  = 1'b0;
        o_job   = '{op: JOB_WRITE, addr: w_wr_addr, data: i_in.rx_byte};
        if (w_accept) begin
            if (i_in.req_type) begin
                n_phase = PH_CMD;
            end else begin
                unique case (r_phase)
                    PH_CMD: begin
                        unique case (i_in.rx_byte)
                            CMD_READ_SP: begin
                                n_pend  = PC_READ;
                                n_phase = PH_PAGE;
                            end
                            CMD_WRITE_SP: begin
                                n_pend  = PC_WRITE;
                                n_phase = PH_PAGE;
                            end
                            CMD_COPY_SP: begin
                                n_pend  = PC_COPY;
                                n_phase = PH_PAGE;
                            end
                            CMD_RECALL: begin
                                n_pend  = PC_RECALL;
                                n_phase = PH_PAGE;
                            end
                            CMD_CONV_T: begin
                                n_phase = PH_IDLE;
                            end
                            CMD_CONV_V: begin
                                o_push   = 1'b1;
                                o_job.op = JOB_CONV_V;
                                n_phase  = PH_IDLE;
                            end
                            default: begin
                                o_push   = 1'b1;
                                o_job.op = JOB_ERROR;
                                n_phase  = PH_IDLE;
                            end
                        endcase
                    end
                    PH_PAGE: begin
                        n_phase = PH_IDLE;
                        if (32'(i_in.rx_byte) < PAGES) begin
                            n_base = w_page_base;
                            if (r_pend == PC_READ) begin
                                o_push     = 1'b1;
                                o_job.op   = JOB_READ;
                                o_job.addr = w_page_base;
                            end else if (r_pend == PC_WRITE) begin
                                n_wcnt  = 3'd0;
                                n_phase = PH_WRITE;
                            end
                        end
                    end
                    PH_WRITE: begin
                        // page 0 bytes 1..6 are read-only: drop the data
                        o_push = !(w_wr_addr >= ADDR_W'(1) && w_wr_addr <= ADDR_W'(6));
                        n_wcnt = r_wcnt + 3'd1;
                        if (r_wcnt == 3'(PAGE_BYTES - 1)) begin
                            n_phase = PH_IDLE;
                        end
                    end
                    PH_IDLE: begin
                        n_phase = PH_IDLE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_CMD;
            r_pend  <= PC_NONE;
            r_base  <= '0;
            r_wcnt  <= '0;
        end else begin
            r_phase <= n_phase;
            r_pend  <= n_pend;
            r_base  <= n_base;
            r_wcnt  <= n_wcnt;
        end
    end

endmodule

@@ design/obm_queue.sv @@
module obm_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  obm_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output obm_pkg::t_job o_head
);
    import obm_pkg::*;

    localparam int QW = $clog2(QUEUE_DEPTH);

    t_job          r_slot [QUEUE_DEPTH];
    logic [QW-1:0] r_wr, r_rd;
    logic [QW:0]   r_count;

    assign o_full  = (r_count == (QW+1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_slot[r_rd];

    // Store pushed jobs
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr] <= i_job;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + QW'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + QW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + (QW+1)'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - (QW+1)'(1);
            end
        end
    end

endmodule

@@ design/obm_back.sv @@
module obm_back #(
    parameter int PAGES = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  obm_pkg::t_cfg i_cfg,
    input  logic          i_empty,
    input  obm_pkg::t_job i_head,
    output logic          o_pop,
    obm_out_if.source     o_out
);
    import obm_pkg::*;

    localparam int DEPTH = PAGES * PAGE_BYTES;
    localparam int AW    = $clog2(DEPTH);

    typedef enum logic {B_IDLE, B_READ} t_state;

    t_state          r_state, n_state;
    logic [AW-1:0]   r_idx, n_idx;
    logic [3:0]      r_cnt, n_cnt;
    logic [7:0]      r_crc, n_crc;
    logic [7:0]      r_ctl0, n_ctl0;
    logic [9:0]      r_volt, n_volt;
    logic [DEPTH-1:0] r_valid;
    logic            r_ov, n_ov;
    logic [7:0]      r_otx, n_otx;
    logic            r_oerr, n_oerr;
    logic            r_olast, n_olast;

    logic [7:0]      r_mem [DEPTH];
    logic [7:0]      r_rd_data;

    logic            w_we;
    logic [AW-1:0]   w_head_addr;
    logic            w_out_free;
    logic signed [15:0] w_temp;
    logic [15:0]     w_curr;
    logic [7:0]      w_byte;

    assign w_head_addr = i_head.addr[AW-1:0];
    assign w_out_free  = !r_ov || o_out.ready;

    // Clamp temperature, sign-extend current
    always_comb begin
        if (i_cfg.temperature_q8 > T_MAX) begin
            w_temp = T_MAX;
        end else if (i_cfg.temperature_q8 < T_MIN) begin
            w_temp = T_MIN;
        end else begin
            w_temp = i_cfg.temperature_q8;
        end
        w_curr = {{6{i_cfg.current_reading[9]}}, i_cfg.current_reading};
    end

    // Page byte at the read index, with page 0 mirrors
    always_comb begin
        case (r_idx)
            AW'(0): w_byte = r_ctl0;
            AW'(1): w_byte = w_temp[7:0] & 8'hF8;
            AW'(2): w_byte = w_temp[15:8];
            AW'(3): w_byte = r_volt[7:0];
            AW'(4): w_byte = {6'b0, r_volt[9:8]};
            AW'(5): w_byte = w_curr[7:0];
            AW'(6): w_byte = w_curr[15:8];
            default: w_byte = r_valid[r_idx] ? r_rd_data : 8'h00;
        endcase
    end

    // Execute jobs and stream page reads
    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_cnt   = r_cnt;
        n_crc   = r_crc;
        n_ctl0  = r_ctl0;
        n_volt  = r_volt;
        n_ov    = r_ov && !o_out.ready;
        n_otx   = r_otx;
        n_oerr  = r_oerr;
        n_olast = r_olast;
        o_pop   = 1'b0;
        w_we    = 1'b0;
        unique case (r_state)
            B_IDLE: begin
                if (!i_empty) begin
                    unique case (i_head.op)
                        JOB_READ: begin
                            o_pop   = 1'b1;
                            n_idx   = w_head_addr;
                            n_cnt   = 4'd0;
                            n_crc   = 8'h00;
                            n_state = B_READ;
                        end
                        JOB_WRITE: begin
                            o_pop = 1'b1;
                            w_we  = 1'b1;
                            if (w_head_addr == AW'(0)) begin
                                n_ctl0 = i_head.data;
                            end
                        end
                        JOB_CONV_V: begin
                            o_pop  = 1'b1;
                            n_volt = r_ctl0[3] ? i_cfg.vdd_voltage : i_cfg.vad_voltage;
                        end
                        JOB_ERROR: begin
                            if (w_out_free) begin
                                o_pop   = 1'b1;
                                n_ov    = 1'b1;
                                n_otx   = 8'h00;
                                n_oerr  = 1'b1;
                                n_olast = 1'b1;
                            end
                        end
                    endcase
                end
            end
            B_READ: begin
                if (w_out_free) begin
                    n_ov   = 1'b1;
                    n_oerr = 1'b0;
                    if (r_cnt == 4'(PAGE_BYTES)) begin
                        n_otx   = r_crc;
                        n_olast = 1'b1;
                        n_state = B_IDLE;
                    end else begin
                        n_otx   = w_byte;
                        n_olast = 1'b0;
                        n_crc   = crc8_step(r_crc, w_byte);
                        n_cnt   = r_cnt + 4'd1;
                        if (r_cnt < 4'(PAGE_BYTES - 1)) begin
                            n_idx = r_idx + AW'(1);
                        end
                    end
                end
            end
        endcase
    end

    // Page memory: read data follows the next index
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_head_addr] <= i_head.data;
        end
        r_rd_data <= r_mem[n_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_idx   <= '0;
            r_cnt   <= '0;
            r_crc   <= '0;
            r_ctl0  <= CTL0_RESET;
            r_volt  <= '0;
            r_valid <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_cnt   <= n_cnt;
            r_crc   <= n_crc;
            r_ctl0  <= n_ctl0;
            r_volt  <= n_volt;
            r_ov    <= n_ov;
            if (w_we) begin
                r_valid[w_head_addr] <= 1'b1;
            end
        end
        r_otx   <= n_otx;
        r_oerr  <= n_oerr;
        r_olast <= n_olast;
    end

    assign o_out.valid       = r_ov;
    assign o_out.tx_byte     = r_otx;
    assign o_out.is_error    = r_oerr;
    assign o_out.last_of_run = r_olast;

endmodule

@@ design/onewire_battery_monitor_slave.sv @@
// Function-command layer of a 1-Wire battery-monitor slave. Each input word is a
// received bus byte or a bus reset; the front end takes one word per cycle while
// its four-entry job queue has room, so bus bytes wait on a page read in progress
// only when the queue is full. The back end drains the queue: a write or Convert V
// job is done on its pop, an error job when output is free, and a Read Scratchpad
// job loads its start index, then sends the eight page bytes and the CRC8 at one per
// cycle, the CRC updated a byte per cycle, slowed only by a held output word. Page 0
// bytes 0, 3 and 4 live in registers and 1, 2, 5 and 6 mirror the configuration
// registers; the other bytes are in a PAGES*8 byte memory with a valid bit per byte,
// unwritten bytes reading as zero. Configuration writes are taken every cycle.
module onewire_battery_monitor_slave #(
    parameter int PAGES = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    obm_in_if.sink     i_in,
    obm_out_if.source  o_out,
    obm_cfg_if.sink    i_cfg
);
    import obm_pkg::*;

    t_cfg r_cfg;
    logic w_push, w_pop, w_q_full, w_q_empty;
    t_job w_job, w_head;

    assign i_cfg.ready = 1'b1;

    // Hold configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_TEMP: r_cfg.temperature_q8  <= i_cfg.data;
                REG_CURR: r_cfg.current_reading <= i_cfg.data[9:0];
                REG_VAD:  r_cfg.vad_voltage     <= i_cfg.data[9:0];
                REG_VDD:  r_cfg.vdd_voltage     <= i_cfg.data[9:0];
                default:  r_cfg <= r_cfg;
            endcase
        end
    end

    obm_front #(.PAGES(PAGES)) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_q_full (w_q_full),
        .o_push   (w_push),
        .o_job    (w_job)
    );

    obm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job),
        .o_full  (w_q_full),
        .i_pop   (w_pop),
        .o_empty (w_q_empty),
        .o_head  (w_head)
    );

    obm_back #(.PAGES(PAGES)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_empty (w_q_empty),
        .i_head  (w_head),
        .o_pop   (w_pop),
        .o_out   (o_out)
    );

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_push && w_q_full))
        else $error("job pushed into a full queue");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_pop && w_q_empty))
        else $error("job popped from an empty queue");

    a_reset_no_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && i_in.req_type) |-> !w_push)
        else $error("bus reset produced a job");

    a_error_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.is_error) |-> (o_out.tx_byte == 8'h00 && o_out.last_of_run))
        else $error("error word malformed");
`endif

endmodule

@@ tb/sv/onewire_battery_monitor_slave_test.sv @@
module onewire_battery_monitor_slave_test;
    timeunit 1ns;
    timeprecision 1ps;

    import obm_pkg::*;

    localparam int PAGES          = 8;
    localparam int STORE_BYTES    = PAGES * PAGE_BYTES;
    localparam int CLK_HALF       = 5;
    localparam int RESET_CYCLES   = 8;
    localparam int SETTLE_CYCLES  = 40;
    localparam int CYCLE_LIMIT    = 400000;
    localparam int AD_BIT         = 3;
    localparam int WORDS_PER_MODE = 15;

    typedef enum logic [1:0] {
        AWAIT_CMD,
        AWAIT_PAGE,
        TAKE_DATA,
        IGNORE_REST
    } t_bus_phase;

    typedef enum logic [2:0] {
        FN_NONE,
        FN_READ,
        FN_WRITE,
        FN_COPY,
        FN_RECALL
    } t_fn_cmd;

    typedef struct {
        logic [7:0] tx_byte;
        logic       is_error;
        logic       last_of_run;
    } t_reply;

    logic i_clk = 1'b0;
    logic i_rst_n;

    obm_in_if  in_bus ();
    obm_out_if out_bus ();
    obm_cfg_if cfg_bus ();

    onewire_battery_monitor_slave #(
        .PAGES(PAGES)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus),
        .i_cfg   (cfg_bus)
    );

    // Shadow of the slave: page image, transaction state, register copies
    logic [7:0]        page_mem [STORE_BYTES];
    t_bus_phase        bus_phase;
    t_fn_cmd           fn_cmd;
    logic [2:0]        sel_page;
    logic [3:0]        wr_count;
    logic signed [15:0] cfg_temp;
    logic signed [9:0]  cfg_curr;
    logic [9:0]         cfg_vad;
    logic [9:0]         cfg_vdd;

    // Reply words the slave still owes the master, oldest first
    t_reply bus_replies[$];

    int idle_pct;
    int stall_pct;
    int items_sent;
    int replies_checked;
    int reg_writes;
    int fail_count;
    int cycle_count;

    always #(CLK_HALF) i_clk = ~i_clk;

    // Run-away guard
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Stall the reply channel at random
    always @(negedge i_clk) begin
        out_bus.ready <= ($urandom_range(99) >= stall_pct);
    end

    // Compare each accepted reply word with the oldest one owed
    always @(posedge i_clk) begin
        t_reply want;
        if (i_rst_n && out_bus.valid && out_bus.ready) begin
            if (bus_replies.size() == 0) begin
                $error("unexpected reply word: tx_byte=%h is_error=%b last_of_run=%b",
                       out_bus.tx_byte, out_bus.is_error, out_bus.last_of_run);
                fail_count++;
            end else begin
                want = bus_replies.pop_front();
                replies_checked++;
                if (out_bus.tx_byte !== want.tx_byte) begin
                    $error("tx_byte: expected %h, got %h", want.tx_byte, out_bus.tx_byte);
                    fail_count++;
                end
                if (out_bus.is_error !== want.is_error) begin
                    $error("is_error: expected %b, got %b", want.is_error, out_bus.is_error);
                    fail_count++;
                end
                if (out_bus.last_of_run !== want.last_of_run) begin
                    $error("last_of_run: expected %b, got %b",
                           want.last_of_run, out_bus.last_of_run);
                    fail_count++;
                end
            end
        end
    end

    // Page byte as the master sees it, with the mirrored register fields
    function automatic logic [7:0] page_view(input int idx);
        logic signed [15:0] t;
        logic [15:0]        c;
        t = cfg_temp;
        if (t > T_MAX) begin
            t = T_MAX;
        end else if (t < T_MIN) begin
            t = T_MIN;
        end
        c = {{6{cfg_curr[9]}}, cfg_curr};
        case (idx)
            1: begin
                return t[7:0] & 8'hF8;
            end
            2: begin
                return t[15:8];
            end
            5: begin
                return c[7:0];
            end
            6: begin
                return c[15:8];
            end
            default: begin
                return page_mem[idx];
            end
        endcase
    endfunction

    // Dallas CRC8, shifted in one bit at a time, LSB first
    function automatic logic [7:0] dallas_crc_add(input logic [7:0] crc, input logic [7:0] data);
        logic mix;
        for (int i = 0; i < 8; i++) begin
            mix = crc[0] ^ data[i];
            crc = crc >> 1;
            if (mix) begin
                crc = crc ^ 8'h8C;
            end
        end
        return crc;
    endfunction

    task automatic push_reply(input logic [7:0] tx, input logic err, input logic last);
        t_reply r;
        r.tx_byte     = tx;
        r.is_error    = err;
        r.last_of_run = last;
        bus_replies.push_back(r);
    endtask

    // Advance the shadow by one accepted bus word and queue the replies it owes
    task automatic slave_take_word(input logic rst_req, input logic [7:0] b);
        logic [7:0] crc;
        logic [7:0] v;
        logic [9:0] volt;
        int         idx;
        if (rst_req) begin
            bus_phase = AWAIT_CMD;
            return;
        end
        case (bus_phase)
            AWAIT_CMD: begin
                bus_phase = AWAIT_PAGE;
                case (b)
                    CMD_READ_SP: begin
                        fn_cmd = FN_READ;
                    end
                    CMD_WRITE_SP: begin
                        fn_cmd = FN_WRITE;
                    end
                    CMD_COPY_SP: begin
                        fn_cmd = FN_COPY;
                    end
                    CMD_RECALL: begin
                        fn_cmd = FN_RECALL;
                    end
                    CMD_CONV_T: begin
                        bus_phase = IGNORE_REST;
                    end
                    CMD_CONV_V: begin
                        volt = page_mem[0][AD_BIT] ? cfg_vdd : cfg_vad;
                        page_mem[3] = volt[7:0];
                        page_mem[4] = {6'b0, volt[9:8]};
                        bus_phase = IGNORE_REST;
                    end
                    default: begin
                        push_reply(8'h00, 1'b1, 1'b1);
                        bus_phase = IGNORE_REST;
                    end
                endcase
            end
            AWAIT_PAGE: begin
                if (b >= PAGES) begin
                    bus_phase = IGNORE_REST;
                end else begin
                    sel_page  = b[2:0];
                    bus_phase = IGNORE_REST;
                    if (fn_cmd == FN_READ) begin
                        crc = 8'h00;
                        for (int i = 0; i < PAGE_BYTES; i++) begin
                            v   = page_view(int'(sel_page) * PAGE_BYTES + i);
                            crc = dallas_crc_add(crc, v);
                            push_reply(v, 1'b0, 1'b0);
                        end
                        push_reply(crc, 1'b0, 1'b1);
                    end else if (fn_cmd == FN_WRITE) begin
                        wr_count  = '0;
                        bus_phase = TAKE_DATA;
                    end
                end
            end
            TAKE_DATA: begin
                // Page 0 bytes 1..6 are read-only; the count still moves on
                idx = int'(sel_page) * PAGE_BYTES + int'(wr_count);
                if (!(idx >= 1 && idx <= 6)) begin
                    page_mem[idx] = b;
                end
                wr_count++;
                if (wr_count >= PAGE_BYTES) begin
                    wr_count  = '0;
                    bus_phase = IGNORE_REST;
                end
            end
            default: begin
            end
        endcase
    endtask

    // Send one bus word, with random idle cycles ahead of it
    task automatic send_item(input logic rst_req, input logic [7:0] b);
        while ($urandom_range(99) < idle_pct) begin
            in_bus.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_bus.valid    <= 1'b1;
        in_bus.req_type <= rst_req;
        in_bus.rx_byte  <= b;
        do @(posedge i_clk); while (!(in_bus.valid && in_bus.ready));
        slave_take_word(rst_req, b);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic bus_reset();
        send_item(1'b1, 8'($urandom_range(255)));
    endtask

    // Drop valid, wait for every owed reply, then let queued jobs drain
    task automatic drain_and_settle();
        in_bus.valid <= 1'b0;
        while (bus_replies.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] index, input logic [15:0] data);
        @(negedge i_clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= index;
        cfg_bus.data  <= data;
        do @(posedge i_clk); while (!(cfg_bus.valid && cfg_bus.ready));
        case (index)
            REG_TEMP: begin
                cfg_temp = data;
            end
            REG_CURR: begin
                cfg_curr = data[9:0];
            end
            REG_VAD: begin
                cfg_vad = data[9:0];
            end
            REG_VDD: begin
                cfg_vdd = data[9:0];
            end
            default: begin
            end
        endcase
        reg_writes++;
        @(negedge i_clk);
        cfg_bus.valid <= 1'b0;
    endtask

    task automatic program_regs(input logic [15:0] t, input logic [9:0] c,
                                input logic [9:0] a, input logic [9:0] d);
        write_reg(REG_TEMP, t);
        write_reg(REG_CURR, {{6{c[9]}}, c});
        write_reg(REG_VAD, {6'b0, a});
        write_reg(REG_VDD, {6'b0, d});
    endtask

    // Power-up page image with registers at reset
    task automatic test_reset_image();
        bus_reset();
        send_item(1'b0, CMD_READ_SP);
        send_item(1'b0, 8'h00);
    endtask

    // Every function command, read-only bytes, overrun, bad page, unknown command
    task automatic test_command_set();
        bus_reset();
        send_item(1'b0, CMD_WRITE_SP);
        send_item(1'b0, 8'h00);
        send_item(1'b0, 8'h0B);
        repeat (6) send_item(1'b0, 8'hFF);
        send_item(1'b0, 8'hA5);
        send_item(1'b0, 8'h3C);
        bus_reset();
        send_item(1'b0, CMD_CONV_V);
        bus_reset();
        send_item(1'b0, CMD_CONV_T);
        bus_reset();
        send_item(1'b0, CMD_COPY_SP);
        send_item(1'b0, 8'h01);
        bus_reset();
        send_item(1'b0, CMD_RECALL);
        send_item(1'b0, 8'h07);
        bus_reset();
        send_item(1'b0, CMD_READ_SP);
        send_item(1'b0, 8'(PAGES));
        bus_reset();
        send_item(1'b0, 8'h00);
        send_item(1'b0, CMD_READ_SP);
        bus_reset();
        send_item(1'b0, CMD_READ_SP);
        send_item(1'b0, 8'h00);
    endtask

    // One register setting: set AD, convert V, then read page 0 back
    task automatic check_setting(input logic [15:0] t, input logic [9:0] c,
                                 input logic [9:0] a, input logic [9:0] d,
                                 input logic [7:0] ctl0);
        drain_and_settle();
        program_regs(t, c, a, d);
        bus_reset();
        send_item(1'b0, CMD_WRITE_SP);
        send_item(1'b0, 8'h00);
        send_item(1'b0, ctl0);
        bus_reset();
        send_item(1'b0, CMD_CONV_V);
        bus_reset();
        send_item(1'b0, CMD_READ_SP);
        send_item(1'b0, 8'h00);
    endtask

    // Register extremes, including temperatures beyond both clamp limits
    task automatic test_register_extremes();
        idle_pct  = 15;
        stall_pct = 15;
        check_setting(T_MAX, 10'h1FF, 10'h3FF, 10'h000, 8'hFF);
        check_setting(T_MIN, 10'h200, 10'h000, 10'h3FF, 8'h00);
        check_setting(16'h7FFF, 10'h000, 10'h2AA, 10'h155, 8'h08);
        check_setting(16'h8000, 10'h3FF, 10'h155, 10'h2AA, 8'hF7);
    endtask

    function automatic logic [7:0] pick_page();
        if ($urandom_range(9) == 0) begin
            return 8'($urandom_range(255, PAGES));
        end
        return 8'($urandom_range(PAGES - 1));
    endfunction

    // One transaction, mostly well-formed, with random content
    task automatic run_transaction();
        int         pick;
        int         n;
        logic [7:0] b;
        if ($urandom_range(19) != 0) begin
            bus_reset();
        end
        pick = $urandom_range(99);
        if (pick < 35) begin
            send_item(1'b0, CMD_READ_SP);
            send_item(1'b0, pick_page());
            repeat ($urandom_range(2)) send_item(1'b0, 8'($urandom_range(255)));
        end else if (pick < 60) begin
            send_item(1'b0, CMD_WRITE_SP);
            send_item(1'b0, pick_page());
            n = $urandom_range(1) ? PAGE_BYTES + $urandom_range(2)
                                  : $urandom_range(PAGE_BYTES - 1);
            repeat (n) send_item(1'b0, 8'($urandom_range(255)));
        end else if (pick < 70) begin
            send_item(1'b0, CMD_CONV_V);
        end else if (pick < 78) begin
            send_item(1'b0, $urandom_range(1) ? CMD_COPY_SP : CMD_RECALL);
            send_item(1'b0, pick_page());
        end else if (pick < 82) begin
            send_item(1'b0, CMD_CONV_T);
        end else if (pick < 88) begin
            do begin
                b = 8'($urandom_range(255));
            end while (b == CMD_READ_SP || b == CMD_WRITE_SP || b == CMD_COPY_SP ||
                       b == CMD_RECALL || b == CMD_CONV_T || b == CMD_CONV_V);
            send_item(1'b0, b);
            repeat ($urandom_range(1)) send_item(1'b0, 8'($urandom_range(255)));
        end else begin
            repeat ($urandom_range(4, 1)) begin
                send_item(1'($urandom_range(1)), 8'($urandom_range(255)));
            end
        end
    endtask

    // Random traffic under each pacing mode, fresh register values per mode
    task automatic test_random_traffic();
        int pace [4][2];
        int target;
        logic [15:0] t;
        pace = '{'{0, 0}, '{85, 0}, '{0, 85}, '{15, 15}};
        for (int m = 0; m < 4; m++) begin
            drain_and_settle();
            if ($urandom_range(3) == 0) begin
                t = 16'($urandom);
            end else begin
                t = 16'(int'($urandom_range(46080)) - 14080);
            end
            program_regs(t, 10'($urandom), 10'($urandom), 10'($urandom));
            idle_pct  = pace[m][0];
            stall_pct = pace[m][1];
            target    = items_sent + WORDS_PER_MODE;
            while (items_sent < target) begin
                run_transaction();
            end
        end
    endtask

    initial begin
        in_bus.valid    = 1'b0;
        in_bus.req_type = 1'b0;
        in_bus.rx_byte  = 8'h00;
        out_bus.ready   = 1'b0;
        cfg_bus.valid   = 1'b0;
        cfg_bus.index   = REG_TEMP;
        cfg_bus.data    = 16'h0000;
        i_rst_n         = 1'b0;

        // Shadow state after reset
        foreach (page_mem[i]) begin
            page_mem[i] = 8'h00;
        end
        page_mem[0]     = CTL0_RESET;
        bus_phase       = AWAIT_CMD;
        fn_cmd          = FN_NONE;
        sel_page        = '0;
        wr_count        = '0;
        cfg_temp        = '0;
        cfg_curr        = '0;
        cfg_vad         = '0;
        cfg_vdd         = '0;
        idle_pct        = 0;
        stall_pct       = 0;
        items_sent      = 0;
        replies_checked = 0;
        reg_writes      = 0;
        fail_count      = 0;
        cycle_count     = 0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_image();
        test_command_set();
        test_register_extremes();
        test_random_traffic();
        drain_and_settle();

        $display("Sent %0d bus words and %0d register writes, checked %0d reply words.",
                 items_sent, reg_writes, replies_checked);
        $display("Covered all function commands, bad pages, read-only bytes, clamping, pacing.");
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
